// ===== hw/rtl/lcrl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrl_pkg
// Types and constants shared by the longest common run length core and its
// cells.
// ----------------------------------------------------------------------------
package lcrl_pkg;

  localparam int unsigned SymW = 8;
  localparam int unsigned OutW = 9;
  localparam logic [OutW-1:0] RunMax = 9'h1FF;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            second_sequence;
    logic            carries_symbol;
    logic            last;
  } in_word_t;

  typedef struct packed {
    logic [OutW-1:0] longest_run;
    logic            truncated;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_STREAM,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic            step;
    logic            clear;
    logic [SymW-1:0] symbol;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/lcrl_cell.sv =====
// ----------------------------------------------------------------------------
// lcrl_cell
// One cell of the row: holds a first-sequence symbol, its diagonal run and
// the best run seen so far from the left.
// ----------------------------------------------------------------------------
module lcrl_cell
  import lcrl_pkg::*;
#(
  parameter int unsigned RunW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic            load_i,
  input  logic [RunW-1:0] run_i,
  input  logic [RunW-1:0] best_i,
  output logic [RunW-1:0] run_o,
  output logic [RunW-1:0] best_o
);

  logic [SymW-1:0] sym_q, sym_d;
  logic            vld_q, vld_d;
  logic [RunW-1:0] run_q, run_d;
  logic [RunW-1:0] best_q, best_d;
  logic [RunW-1:0] cand;
  logic            hit;

  always_comb begin
    hit   = ctrl_i.step && vld_q && (sym_q == ctrl_i.symbol);
    cand  = hit ? run_i + RunW'(1) : '0;
    sym_d = load_i ? ctrl_i.symbol : sym_q;
    vld_d = vld_q;
    run_d = run_q;
    best_d = best_q;
    if (best_i > best_d) begin
      best_d = best_i;
    end
    if (cand > best_d) begin
      best_d = cand;
    end
    if (load_i) begin
      vld_d = 1'b1;
    end
    if (ctrl_i.step && vld_q) begin
      run_d = cand;
    end
    if (ctrl_i.clear) begin
      vld_d  = 1'b0;
      run_d  = '0;
      best_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      run_q  <= '0;
      best_q <= '0;
    end else begin
      vld_q  <= vld_d;
      run_q  <= run_d;
      best_q <= best_d;
    end
  end

  assign run_o  = run_q;
  assign best_o = best_q;

endmodule

// ===== hw/rtl/longest_common_run_length_core.sv =====
// ----------------------------------------------------------------------------
// longest_common_run_length_core
// Longest common substring length of two byte sequences on a row of cells.
// ----------------------------------------------------------------------------
// Usage: drive a word on in_word_i and raise start; the word is taken at a
// rising edge where start is high and busy is low. First-sequence words
// load one symbol each into the next free cell (cell selected by the stored
// length). Second-sequence words then stream, one per cycle: every loaded
// cell updates its diagonal run from its left neighbor's run in the same
// cycle. A second-sequence word that ends the first sequence early is
// legal; first-sequence words while streaming are dropped. Symbols past
// MAX_LEN in either sequence are dropped and flag truncated.
// After the last second-sequence word, busy stays high while the per-cell
// best runs ripple to the end of the row; the result then shows on result_o
// with result_valid_o high for one cycle. A new word may be taken in the
// cycle the result shows.
// The receiver cannot stall. Reset clears all cell runs, counters and the
// phase; stored symbols keep whatever they held.
// ----------------------------------------------------------------------------
module longest_common_run_length_core
  import lcrl_pkg::*;
#(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word_i,
  output logic      result_valid_o,
  output out_word_t result_o
);

  localparam int unsigned LenW = $clog2(MAX_LEN + 1);
  localparam int unsigned CntW = $clog2(MAX_LEN);
  localparam int unsigned ExtW = (LenW > OutW) ? LenW : OutW;

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] sc_q, sc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            out_vld_q;
  out_word_t       result_q, result_d;

  logic            accept;
  logic            drain_done;
  logic            load_en;
  cell_ctrl_t      ctrl;
  logic [LenW-1:0] run_chain  [MAX_LEN+1];
  logic [LenW-1:0] best_chain [MAX_LEN+1];
  logic [ExtW-1:0] best_ext;

  assign accept     = start && !busy;
  assign drain_done = (cnt_q == CntW'(MAX_LEN - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (in_word_i.second_sequence && in_word_i.last) begin
            state_d = ST_DRAIN;
          end else if (in_word_i.second_sequence || in_word_i.last) begin
            state_d = ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        if (accept && in_word_i.second_sequence && in_word_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    busy        = (state_q == ST_DRAIN);
    ctrl.symbol = in_word_i.symbol;
    ctrl.clear  = (state_q == ST_DRAIN) && drain_done;
    load_en     = 1'b0;
    ctrl.step   = 1'b0;
    len_d       = len_q;
    sc_d        = sc_q;
    ovf_d       = ovf_q;
    cnt_d       = (state_q == ST_DRAIN && !drain_done) ? cnt_q + CntW'(1) : '0;
    if (accept && in_word_i.carries_symbol) begin
      if (!in_word_i.second_sequence && state_q == ST_LOAD) begin
        if (len_q != LenW'(MAX_LEN)) begin
          load_en = 1'b1;
          len_d   = len_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end else if (in_word_i.second_sequence) begin
        if (sc_q != LenW'(MAX_LEN)) begin
          ctrl.step = 1'b1;
          sc_d      = sc_q + LenW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end
    if (ctrl.clear) begin
      len_d = '0;
      sc_d  = '0;
      ovf_d = 1'b0;
    end
  end

  assign run_chain[0]  = '0;
  assign best_chain[0] = '0;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic load;
    assign load = load_en && (len_q == LenW'(i));
    lcrl_cell #(
      .RunW (LenW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .load_i (load),
      .run_i  (run_chain[i]),
      .best_i (best_chain[i]),
      .run_o  (run_chain[i+1]),
      .best_o (best_chain[i+1])
    );
  end

  always_comb begin
    best_ext             = ExtW'(best_chain[MAX_LEN]);
    result_d.longest_run = (best_ext > ExtW'(RunMax)) ? RunMax : best_ext[OutW-1:0];
    result_d.truncated   = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      len_q     <= '0;
      sc_q      <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      sc_q      <= sc_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      out_vld_q <= ctrl.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = result_q;

  a_result_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_DRAIN))
    else $error("result without drain");

  a_last_starts_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_word_i.second_sequence && in_word_i.last) |=> busy)
    else $error("last word did not start drain");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q <= LenW'(MAX_LEN)) && (sc_q <= LenW'(MAX_LEN)))
    else $error("length counter out of range");

  a_clear_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (len_q == '0) && !ovf_q && (state_q == ST_LOAD))
    else $error("job state not cleared");

endmodule

// ===== bench/longest_common_run_length_checker.sv =====
// ----------------------------------------------------------------------------
// longest_common_run_length_checker
// Watches the word and result channels of the longest common run length core,
// keeps its own row of stored symbols and diagonal runs, predicts the result
// of every job and compares each result that shows with the oldest prediction.
// ----------------------------------------------------------------------------
module longest_common_run_length_checker
  import lcrl_pkg::*;
#(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_word_t    word_i,
  input  logic        result_valid_i,
  input  out_word_t   result_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SymW-1:0] row_symbols [MAX_LEN];
  int unsigned     row_runs [MAX_LEN];
  int unsigned     row_len;
  int unsigned     cols_seen;
  int unsigned     best_len;
  logic            dropped;
  state_e          phase;
  out_word_t       job_results [$];
  int unsigned     mismatches = 0;

  function automatic void open_stream();
    foreach (row_runs[i]) row_runs[i] = 0;
    cols_seen = 0;
    phase = ST_STREAM;
  endfunction

  function automatic void clear_job();
    foreach (row_runs[i]) row_runs[i] = 0;
    row_len = 0;
    cols_seen = 0;
    best_len = 0;
    dropped = 1'b0;
    phase = ST_LOAD;
  endfunction

  function automatic void step_row(input in_word_t w);
    out_word_t res;
    int unsigned left_run;
    if (!w.second_sequence) begin
      if (phase == ST_LOAD) begin
        if (w.carries_symbol) begin
          if (row_len < MAX_LEN) begin
            row_symbols[row_len] = w.symbol;
            row_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (w.last) open_stream();
      end
    end else begin
      if (phase == ST_LOAD) open_stream();
      if (w.carries_symbol) begin
        if (cols_seen < MAX_LEN) begin
          cols_seen++;
          // walk right to left so each cell sees its neighbor's old run
          for (int unsigned c = row_len; c > 0; c--) begin
            left_run = (c > 1) ? row_runs[c-2] : 0;
            if (row_symbols[c-1] == w.symbol) begin
              row_runs[c-1] = left_run + 1;
              if (left_run + 1 > best_len) best_len = left_run + 1;
            end else begin
              row_runs[c-1] = 0;
            end
          end
        end else begin
          dropped = 1'b1;
        end
      end
      if (w.last) begin
        res.longest_run = (best_len > RunMax) ? RunMax : OutW'(best_len);
        res.truncated = dropped;
        job_results.push_back(res);
        clear_job();
      end
    end
  endfunction

  task automatic flag_result(input string what, input out_word_t want, input out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected run %0d truncated %0b, got run %0d truncated %0b",
               $realtime, what, want.longest_run, want.truncated,
               got.longest_run, got.truncated);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    logic      bad;
    if (!rst_ni) begin
      clear_job();
      job_results.delete();
      pending_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (result_valid_i) begin
        if (job_results.size() == 0) begin
          flag_result("result with no job ended", '0, result_i);
        end else begin
          want = job_results.pop_front();
          bad = 1'b0;
          if (result_i.longest_run !== want.longest_run) bad = 1'b1;
          if (result_i.truncated !== want.truncated) bad = 1'b1;
          if (bad) flag_result("wrong result", want, result_i);
        end
      end
      if (start_i && !busy_i) step_row(word_i);
      pending_o <= job_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/longest_common_run_length_core_test.sv =====
// ----------------------------------------------------------------------------
// longest_common_run_length_core_test
// Drives the longest common run length core with directed jobs, long jobs that
// fill and overflow the row, and random short jobs with stray and early-ending
// words, under random start gaps; a checker beside the block judges results.
// ----------------------------------------------------------------------------
module longest_common_run_length_core_test
  import lcrl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLen = 256;
  localparam int unsigned TestWords = 1650;
  localparam int unsigned TailWords = 150;
  localparam int unsigned CycleLimit = 2_000_000;

  localparam int unsigned EndOnSymbol = 0;
  localparam int unsigned EndOnEmpty = 1;
  localparam int unsigned EndBySecond = 2;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_word_t    in_word_i;
  logic        result_valid_o;
  out_word_t   result_o;
  int unsigned mismatches;
  int unsigned pending;

  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  longest_common_run_length_core #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_word_i     (in_word_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  longest_common_run_length_checker #(
    .MAX_LEN(MaxLen)
  ) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .word_i          (in_word_i),
    .result_valid_i  (result_valid_o),
    .result_i        (result_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic put_word(input logic [SymW-1:0] sym, input logic second,
                          input logic carries, input logic last_flag, input bit counts);
    in_word_t w;
    w.symbol = sym;
    w.second_sequence = second;
    w.carries_symbol = carries;
    w.last = last_flag;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (counts) words_sent++;
  endtask

  task automatic send_seq(input bit second, input int unsigned n,
                          input logic [SymW-1:0] base, input int unsigned spread,
                          input int unsigned end_mode, input bit noisy);
    logic [SymW-1:0] sym;
    for (int unsigned k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        // stray words: no-op, or a first-sequence word while streaming
        if (second && k > 0 && $urandom_range(0, 1) == 0)
          put_word(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), 1'b0);
        else
          put_word(8'($urandom), second, 1'b0, 1'b0, 1'b0);
      end
      sym = base + 8'($urandom_range(0, spread));
      put_word(sym, second, 1'b1, (k == n - 1) && (end_mode == EndOnSymbol), 1'b1);
    end
    if (end_mode == EndOnEmpty || (end_mode == EndOnSymbol && n == 0))
      put_word(8'($urandom), second, 1'b0, 1'b1, 1'b1);
  endtask

  initial begin
    logic [SymW-1:0] base;
    int unsigned     spread;
    int unsigned     end_first;
    rst_ni = 1'b0;
    start = 1'b0;
    in_word_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both sequences empty
    put_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    put_word(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1);
    // extreme symbols, a no-op word inside the first sequence
    put_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
    put_word(8'h5A, 1'b0, 1'b0, 1'b0, 1'b1);
    put_word(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
    put_word(8'hFF, 1'b1, 1'b1, 1'b0, 1'b1);
    put_word(8'h00, 1'b1, 1'b1, 1'b0, 1'b1);
    put_word(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
    // first sequence ended early by a second-sequence word
    put_word(8'h41, 1'b0, 1'b1, 1'b0, 1'b1);
    put_word(8'h42, 1'b0, 1'b1, 1'b0, 1'b1);
    put_word(8'h41, 1'b1, 1'b1, 1'b0, 1'b1);
    put_word(8'h42, 1'b1, 1'b1, 1'b1, 1'b1);
    // first-sequence word while streaming is dropped, last flag too
    put_word(8'h07, 1'b0, 1'b1, 1'b1, 1'b1);
    put_word(8'h07, 1'b1, 1'b1, 1'b0, 1'b1);
    put_word(8'h07, 1'b0, 1'b1, 1'b1, 1'b1);
    put_word(8'h07, 1'b1, 1'b1, 1'b1, 1'b1);
    // empty second sequence
    put_word(8'h05, 1'b0, 1'b1, 1'b0, 1'b1);
    put_word(8'h06, 1'b0, 1'b1, 1'b1, 1'b1);
    put_word(8'hA5, 1'b1, 1'b0, 1'b1, 1'b1);
    // second sequence with nothing stored
    put_word(8'h80, 1'b1, 1'b0, 1'b0, 1'b1);
    put_word(8'h09, 1'b1, 1'b1, 1'b1, 1'b1);

    // full row of one symbol, second sequence overflows
    send_seq(1'b0, MaxLen, 8'hFF, 0, EndOnSymbol, 1'b0);
    send_seq(1'b1, MaxLen + 2, 8'hFF, 0, EndOnSymbol, 1'b0);
    // first sequence overflows
    base = 8'($urandom);
    send_seq(1'b0, MaxLen + 2, base, 1, EndOnEmpty, 1'b0);
    send_seq(1'b1, 8, base, 1, EndOnSymbol, 1'b0);

    while (words_sent < TestWords) begin
      idle_on = (words_sent + TailWords < TestWords) && ($urandom_range(0, 3) != 0);
      base = 8'($urandom);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 1;
        2: spread = 3;
        default: spread = 255;
      endcase
      case ($urandom_range(0, 7))
        5, 6: end_first = EndOnEmpty;
        7: end_first = EndBySecond;
        default: end_first = EndOnSymbol;
      endcase
      send_seq(1'b0, $urandom_range(0, 12), base, spread, end_first, 1'b1);
      send_seq(1'b1, $urandom_range(0, 12), base, spread,
               ($urandom_range(0, 3) == 0) ? EndOnEmpty : EndOnSymbol, 1'b1);
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (MaxLen + 16) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
